@@ sv/xgs_pkg.sv @@
package xgs_pkg;

  // Datapath widths
  localparam int unsigned StepW  = 17;  // steps in one segment (2 * 15 * 4095 max)
  localparam int unsigned TickW  = 18;  // ticks in one phase (4 * 65535 max)
  localparam int unsigned SphcW  = 12;
  localparam int unsigned BaseW  = 16;
  localparam int unsigned RampW  = 12;
  localparam int unsigned CoordW = 4;
  localparam int unsigned SegW   = 3;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Item commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STEPS_PER_HALF_CELL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_HALF_PERIOD    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEPS          = 2'd2;

  // Register reset values
  localparam logic [SphcW-1:0] SPHC_RESET = 12'd100;
  localparam logic [BaseW-1:0] BASE_RESET = 16'd1000;
  localparam logic [RampW-1:0] RAMP_RESET = 12'd30;

  // Segment sequence; odd segments move X, even segments move Y
  localparam logic [SegW-1:0] SEG_IDLE   = 3'd0;
  localparam logic [SegW-1:0] SEG_X_BACK = 3'd1;
  localparam logic [SegW-1:0] SEG_Y_BACK = 3'd2;
  localparam logic [SegW-1:0] SEG_X_RUN  = 3'd3;
  localparam logic [SegW-1:0] SEG_Y_RUN  = 3'd4;
  localparam logic [SegW-1:0] SEG_X_FWD  = 3'd5;
  localparam logic [SegW-1:0] SEG_Y_FWD  = 3'd6;

  // Result status codes
  localparam logic [StatW-1:0] ST_NONE     = 3'd0;
  localparam logic [StatW-1:0] ST_ACCEPTED = 3'd1;
  localparam logic [StatW-1:0] ST_THERE    = 3'd2;
  localparam logic [StatW-1:0] ST_RANGE    = 3'd3;
  localparam logic [StatW-1:0] ST_BUSY     = 3'd4;

endpackage

@@ sv/xy_grid_stepper_move_sequencer_core.sv @@
// Step/direction pulse generator for a two-axis gantry moving between grid
// cells. Each input item is either one time tick or a move request; every
// item gives exactly one result with the pin levels, busy flag, status and
// current cell after that item. Items are taken one per clock cycle while results
// are taken: the whole state update (segment select, one 5x12 multiply for
// the segment length and the phase-length compare) sits between the state
// registers and the result register, so a result is registered at its transfer
// and a new item is taken in the same cycle that the held result is taken.
// Configuration writes take effect on the next clock edge; phase lengths use
// the values current when a phase starts, segment lengths when a segment starts.
module xy_grid_stepper_move_sequencer_core #(
  parameter int unsigned BOARD_COLS = 9,
  parameter int unsigned BOARD_ROWS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [xgs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [xgs_pkg::CfgDataW-1:0]      cfg_data_i,
  // items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [xgs_pkg::CoordW-1:0]        target_x_i,
  input  logic [xgs_pkg::CoordW-1:0]        target_y_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              x_step_o,
  output logic                              x_dir_o,
  output logic                              x_enable_n_o,
  output logic                              y_step_o,
  output logic                              y_dir_o,
  output logic                              y_enable_n_o,
  output logic                              busy_res_o,
  output logic [xgs_pkg::StatW-1:0]         status_o,
  output logic [xgs_pkg::CoordW-1:0]        cur_x_o,
  output logic [xgs_pkg::CoordW-1:0]        cur_y_o
);

  localparam int unsigned StepW  = xgs_pkg::StepW;
  localparam int unsigned TickW  = xgs_pkg::TickW;
  localparam int unsigned CoordW = xgs_pkg::CoordW;
  localparam int unsigned SegW   = xgs_pkg::SegW;

  // Phase length: four times longer near either end of a segment, never zero
  function automatic logic [TickW-1:0] phase_len(
    input logic [StepW-1:0]          rem,
    input logic [StepW-1:0]          total,
    input logic [xgs_pkg::RampW-1:0] ramp,
    input logic [xgs_pkg::BaseW-1:0] base
  );
    logic             slow;
    logic [TickW-1:0] p;
    slow = (({1'b0, rem} + TickW'(ramp)) > {1'b0, total}) || (rem < StepW'(ramp));
    p    = slow ? {base, 2'b00} : {2'b00, base};
    if (p == '0) begin
      p = TickW'(1);
    end
    return p;
  endfunction

  // Configuration registers
  logic [xgs_pkg::SphcW-1:0] sphc_q;
  logic [xgs_pkg::BaseW-1:0] base_q;
  logic [xgs_pkg::RampW-1:0] ramp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sphc_q <= xgs_pkg::SPHC_RESET;
      base_q <= xgs_pkg::BASE_RESET;
      ramp_q <= xgs_pkg::RAMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xgs_pkg::CFG_STEPS_PER_HALF_CELL: sphc_q <= cfg_data_i[xgs_pkg::SphcW-1:0];
        xgs_pkg::CFG_BASE_HALF_PERIOD:    base_q <= cfg_data_i[xgs_pkg::BaseW-1:0];
        xgs_pkg::CFG_RAMP_STEPS:          ramp_q <= cfg_data_i[xgs_pkg::RampW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [CoordW-1:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q;
  logic [CoordW-1:0] pos_x_d, pos_y_d, goal_x_d, goal_y_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [StepW-1:0]  total_q, total_d, rem_q, rem_d;
  logic              high_q, high_d, dir_q, dir_d;
  logic [TickW-1:0]  ticks_q, ticks_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic              x_step_q, x_dir_q, x_en_n_q, y_step_q, y_dir_q, y_en_n_q;
  logic              busy_q;
  logic [xgs_pkg::StatW-1:0] status_q, status_d;

  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Move request decode
  logic running, is_move, in_grid, same_cell, move_ok;
  assign running   = seg_q != xgs_pkg::SEG_IDLE;
  assign is_move   = cmd_i == xgs_pkg::CMD_MOVE;
  assign in_grid   = ({1'b0, target_x_i} < (CoordW+1)'(BOARD_COLS)) &&
                     ({1'b0, target_y_i} < (CoordW+1)'(BOARD_ROWS));
  assign same_cell = (target_x_i == pos_x_q) && (target_y_i == pos_y_q);
  assign move_ok   = is_move && !running && in_grid && !same_cell;

  // Tick decode: countdown and end of segment
  logic [TickW-1:0] ticks_dec;
  logic [StepW-1:0] rem_dec;
  logic             tick_phase_end, tick_seg_end;
  assign ticks_dec      = (ticks_q != '0) ? ticks_q - TickW'(1) : '0;
  assign rem_dec        = rem_q - StepW'(1);
  assign tick_phase_end = !is_move && running && (ticks_dec == '0);
  assign tick_seg_end   = tick_phase_end && !high_q && (rem_dec == '0);

  // Segment start request
  logic              start_req;
  logic [SegW-1:0]   start_idx;
  logic [CoordW-1:0] goal_x_n, goal_y_n;
  assign start_req = move_ok || tick_seg_end;
  assign start_idx = move_ok ? xgs_pkg::SEG_X_BACK : seg_q + SegW'(1);
  assign goal_x_n  = move_ok ? target_x_i : goal_x_q;
  assign goal_y_n  = move_ok ? target_y_i : goal_y_q;

  // Find the first non-empty segment at or after start_idx
  logic [CoordW-1:0] dx_abs, dy_abs;
  logic              x_fwd, y_fwd;
  logic [6:1]        nonempty;
  logic              hit;
  logic [SegW-1:0]   pick;
  logic [CoordW:0]   factor;
  logic [StepW-1:0]  seg_len;
  logic              seg_dir;

  assign x_fwd  = goal_x_n >= pos_x_q;
  assign y_fwd  = goal_y_n >= pos_y_q;
  assign dx_abs = x_fwd ? goal_x_n - pos_x_q : pos_x_q - goal_x_n;
  assign dy_abs = y_fwd ? goal_y_n - pos_y_q : pos_y_q - goal_y_n;

  always_comb begin
    nonempty[1] = sphc_q != '0;
    nonempty[2] = sphc_q != '0;
    nonempty[3] = (sphc_q != '0) && (dx_abs != '0);
    nonempty[4] = (sphc_q != '0) && (dy_abs != '0);
    nonempty[5] = sphc_q != '0;
    nonempty[6] = sphc_q != '0;
    hit  = 1'b0;
    pick = xgs_pkg::SEG_IDLE;
    // descending scan leaves the lowest match
    for (int k = 6; k >= 1; k--) begin
      if ((SegW'(k) >= start_idx) && nonempty[k]) begin
        hit  = 1'b1;
        pick = SegW'(k);
      end
    end
  end

  // Length and direction of the picked segment
  always_comb begin
    unique case (pick)
      xgs_pkg::SEG_X_RUN: begin
        factor  = {dx_abs, 1'b0};
        seg_dir = x_fwd;
      end
      xgs_pkg::SEG_Y_RUN: begin
        factor  = {dy_abs, 1'b0};
        seg_dir = y_fwd;
      end
      xgs_pkg::SEG_X_BACK, xgs_pkg::SEG_Y_BACK: begin
        factor  = (CoordW+1)'(1);
        seg_dir = 1'b0;
      end
      default: begin
        factor  = (CoordW+1)'(1);
        seg_dir = 1'b1;
      end
    endcase
  end

  assign seg_len = {{(StepW-CoordW-1){1'b0}}, factor} *
                   {{(StepW-xgs_pkg::SphcW){1'b0}}, sphc_q};

  // Next state
  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    goal_x_d = goal_x_n;
    goal_y_d = goal_y_n;
    seg_d    = seg_q;
    total_d  = total_q;
    rem_d    = rem_q;
    high_d   = high_q;
    dir_d    = dir_q;
    ticks_d  = ticks_q;
    status_d = xgs_pkg::ST_NONE;

    if (!is_move) begin
      if (running) begin
        if (ticks_dec != '0) begin
          ticks_d = ticks_dec;
        end else if (high_q) begin
          high_d  = 1'b0;
          ticks_d = phase_len(rem_q, total_q, ramp_q, base_q);
        end else if (rem_dec != '0) begin
          rem_d   = rem_dec;
          high_d  = 1'b1;
          ticks_d = phase_len(rem_dec, total_q, ramp_q, base_q);
        end
      end
    end else begin
      priority if (running) begin
        status_d = xgs_pkg::ST_BUSY;
      end else if (!in_grid) begin
        status_d = xgs_pkg::ST_RANGE;
      end else if (same_cell) begin
        status_d = xgs_pkg::ST_THERE;
      end else begin
        status_d = xgs_pkg::ST_ACCEPTED;
      end
    end

    // Start the next segment, or finish the move when none is left
    if (start_req) begin
      if (hit) begin
        seg_d   = pick;
        total_d = seg_len;
        rem_d   = seg_len;
        dir_d   = seg_dir;
        high_d  = 1'b1;
        ticks_d = phase_len(seg_len, seg_len, ramp_q, base_q);
      end else begin
        pos_x_d = goal_x_n;
        pos_y_d = goal_y_n;
        seg_d   = xgs_pkg::SEG_IDLE;
        total_d = '0;
        rem_d   = '0;
        high_d  = 1'b0;
        dir_d   = 1'b0;
        ticks_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      seg_q    <= xgs_pkg::SEG_IDLE;
      total_q  <= '0;
      rem_q    <= '0;
      high_q   <= 1'b0;
      dir_q    <= 1'b0;
      ticks_q  <= '0;
    end else if (accept) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      seg_q    <= seg_d;
      total_q  <= total_d;
      rem_q    <= rem_d;
      high_q   <= high_d;
      dir_q    <= dir_d;
      ticks_q  <= ticks_d;
    end
  end

  // Result register: pin levels follow the state after this item
  logic busy_d, x_act, y_act;
  assign busy_d      = seg_d != xgs_pkg::SEG_IDLE;
  assign x_act       = busy_d && seg_d[0];
  assign y_act       = busy_d && !seg_d[0];
  assign out_valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      x_step_q    <= 1'b0;
      x_dir_q     <= 1'b0;
      x_en_n_q    <= 1'b1;
      y_step_q    <= 1'b0;
      y_dir_q     <= 1'b0;
      y_en_n_q    <= 1'b1;
      busy_q      <= 1'b0;
      status_q    <= xgs_pkg::ST_NONE;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        x_step_q <= x_act && high_d;
        x_dir_q  <= x_act && dir_d;
        x_en_n_q <= !x_act;
        y_step_q <= y_act && high_d;
        y_dir_q  <= y_act && dir_d;
        y_en_n_q <= !y_act;
        busy_q   <= busy_d;
        status_q <= status_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign x_step_o     = x_step_q;
  assign x_dir_o      = x_dir_q;
  assign x_enable_n_o = x_en_n_q;
  assign y_step_o     = y_step_q;
  assign y_dir_o      = y_dir_q;
  assign y_enable_n_o = y_en_n_q;
  assign busy_res_o   = busy_q;
  assign status_o     = status_q;
  assign cur_x_o      = pos_x_q;
  assign cur_y_o      = pos_y_q;

  // A running segment always has a phase in progress
  a_phase_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running |-> (ticks_q != '0))
    else $error("running segment with no phase ticks left");

  // Step count stays within the segment length
  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running |-> ((rem_q != '0) && (rem_q <= total_q)))
    else $error("steps remaining out of bounds");

  // A request during a move is reported as busy
  a_busy_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_move && running) |=> (out_valid_q && (status_q == xgs_pkg::ST_BUSY)))
    else $error("request during a move not rejected as busy");

  // Idle results leave both axes at idle levels
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !busy_q) |-> (x_en_n_q && y_en_n_q && !x_step_q && !y_step_q))
    else $error("axis driven while not busy");

endmodule
